// File: design/lob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

  localparam int unsigned SIDE_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(SIDE_DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned ADDR_W     = IDX_W + 1;
  localparam int unsigned ENTRY_W    = 96;
  localparam int unsigned RAM_DEPTH  = 2 * SIDE_DEPTH;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_MODIFY = 2'd1,
    OP_DELETE = 2'd2,
    OP_MATCH  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN_ID = 2'd1,
    ST_SIDE_FULL  = 2'd2,
    ST_DUPLICATE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_CHK,
    S_FP_RD,
    S_FP_EV,
    S_SH_RD,
    S_SH_WR,
    S_RM_RD,
    S_RM_WR,
    S_MT_RD,
    S_MT_EV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] vol;
  } entry_t;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] vol;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] traded;
    logic [31:0] rested;
  } res_t;

endpackage

`default_nettype wire

// File: design/lob_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] order_id;
  logic        side;
  logic [31:0] price;
  logic [31:0] volume;

  modport source (output valid, opcode, order_id, side, price, volume, input ready);
  modport sink   (input valid, opcode, order_id, side, price, volume, output ready);
endinterface

interface lob_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] traded_volume;
  logic [31:0] rested_volume;

  modport source (output valid, status, traded_volume, rested_volume, input ready);
  modport sink   (input valid, status, traded_volume, rested_volume, output ready);
endinterface

`default_nettype wire

// File: design/lob_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/lob_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module lob_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire lob_pkg::req_t req_i,
  output logic               idle_o,
  output logic               done_o,
  output lob_pkg::res_t      res_o,
  input  wire logic          ack_i
);

  lob_pkg::state_e state_q, state_d;

  lob_pkg::opcode_e            op_q, op_d;
  logic [31:0]                 id_q, id_d;
  logic                        side_q, side_d;
  logic [31:0]                 price_q, price_d;
  logic [31:0]                 vol_q, vol_d;
  logic [31:0]                 traded_q, traded_d;
  logic [31:0]                 rested_q, rested_d;
  lob_pkg::status_e            status_q, status_d;
  logic                        found_q, found_d;
  logic [31:0]                 hit_price_q, hit_price_d;
  logic                        cur_side_q, cur_side_d;
  logic [lob_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [lob_pkg::CNT_W-1:0]   pos_q, pos_d;
  logic [lob_pkg::CNT_W-1:0]   cnt_q [2];
  logic [lob_pkg::CNT_W-1:0]   cnt_d [2];

  logic                        ram_we;
  logic [lob_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  lob_pkg::entry_t             ram_wdata, rd;
  logic [lob_pkg::ENTRY_W-1:0] ram_rdata;

  logic                        opp;
  logic [lob_pkg::CNT_W-1:0]   idx_inc, idx_dec;
  logic                        crosses, better;
  logic [31:0]                 fill;

  assign rd      = lob_pkg::entry_t'(ram_rdata);
  assign opp     = ~side_q;
  assign idx_inc = idx_q + lob_pkg::CNT_W'(1);
  assign idx_dec = idx_q - lob_pkg::CNT_W'(1);
  assign crosses = side_q ? (price_q <= rd.price) : (price_q >= rd.price);
  assign better  = side_q ? (price_q < rd.price) : (price_q > rd.price);
  assign fill    = (vol_q < rd.vol) ? vol_q : rd.vol;

  lob_ram #(
    .WIDTH (lob_pkg::ENTRY_W),
    .DEPTH (lob_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lob_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = (req_i.op == lob_pkg::OP_MATCH) ? lob_pkg::S_MT_RD : lob_pkg::S_LK_RD;
        end
      end
      lob_pkg::S_LK_RD: begin
        if (idx_q >= cnt_q[cur_side_q]) begin
          if (cur_side_q) state_d = lob_pkg::S_CHK;
        end else begin
          state_d = lob_pkg::S_LK_EV;
        end
      end
      lob_pkg::S_LK_EV: begin
        state_d = (rd.id == id_q) ? lob_pkg::S_CHK : lob_pkg::S_LK_RD;
      end
      lob_pkg::S_CHK: begin
        if (op_q == lob_pkg::OP_ADD || op_q == lob_pkg::OP_MATCH) begin
          if (found_q || cnt_q[side_q] >= lob_pkg::CNT_W'(lob_pkg::SIDE_DEPTH)) begin
            state_d = lob_pkg::S_FIN;
          end else begin
            state_d = lob_pkg::S_FP_RD;
          end
        end else if (found_q && (op_q == lob_pkg::OP_DELETE || vol_q == 32'd0)) begin
          state_d = lob_pkg::S_RM_RD;
        end else begin
          state_d = lob_pkg::S_FIN;
        end
      end
      lob_pkg::S_FP_RD: begin
        state_d = (idx_q >= cnt_q[side_q]) ? lob_pkg::S_SH_RD : lob_pkg::S_FP_EV;
      end
      lob_pkg::S_FP_EV: begin
        state_d = better ? lob_pkg::S_SH_RD : lob_pkg::S_FP_RD;
      end
      lob_pkg::S_SH_RD: begin
        state_d = (idx_q == pos_q) ? lob_pkg::S_FIN : lob_pkg::S_SH_WR;
      end
      lob_pkg::S_SH_WR: state_d = lob_pkg::S_SH_RD;
      lob_pkg::S_RM_RD: begin
        if (idx_inc >= cnt_q[cur_side_q]) begin
          state_d = (op_q == lob_pkg::OP_MATCH) ? lob_pkg::S_MT_RD : lob_pkg::S_FIN;
        end else begin
          state_d = lob_pkg::S_RM_WR;
        end
      end
      lob_pkg::S_RM_WR: state_d = lob_pkg::S_RM_RD;
      lob_pkg::S_MT_RD: begin
        if (vol_q == 32'd0) begin
          state_d = lob_pkg::S_FIN;
        end else if (cnt_q[opp] == '0) begin
          state_d = lob_pkg::S_LK_RD;
        end else begin
          state_d = lob_pkg::S_MT_EV;
        end
      end
      lob_pkg::S_MT_EV: begin
        if (!crosses) begin
          state_d = lob_pkg::S_LK_RD;
        end else if (fill == rd.vol) begin
          state_d = lob_pkg::S_RM_RD;
        end else begin
          state_d = lob_pkg::S_MT_RD;
        end
      end
      lob_pkg::S_FIN: begin
        if (ack_i) state_d = lob_pkg::S_IDLE;
      end
      default: state_d = lob_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    id_d        = id_q;
    side_d      = side_q;
    price_d     = price_q;
    vol_d       = vol_q;
    traded_d    = traded_q;
    rested_d    = rested_q;
    status_d    = status_q;
    found_d     = found_q;
    hit_price_d = hit_price_q;
    cur_side_d  = cur_side_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d[0]    = cnt_q[0];
    cnt_d[1]    = cnt_q[1];
    ram_we      = 1'b0;
    ram_waddr   = {cur_side_q, idx_q[lob_pkg::IDX_W-1:0]};
    ram_wdata   = '{id: id_q, price: price_q, vol: vol_q};
    ram_raddr   = {cur_side_q, idx_q[lob_pkg::IDX_W-1:0]};
    unique case (state_q)
      lob_pkg::S_IDLE: begin
        if (start_i) begin
          op_d       = req_i.op;
          id_d       = req_i.id;
          side_d     = req_i.side;
          price_d    = req_i.price;
          vol_d      = req_i.vol;
          traded_d   = '0;
          rested_d   = '0;
          status_d   = lob_pkg::ST_OK;
          found_d    = 1'b0;
          cur_side_d = 1'b0;
          idx_d      = '0;
        end
      end
      lob_pkg::S_LK_RD: begin
        if (idx_q >= cnt_q[cur_side_q]) begin
          if (!cur_side_q) begin
            cur_side_d = 1'b1;
            idx_d      = '0;
          end
        end
      end
      lob_pkg::S_LK_EV: begin
        if (rd.id == id_q) begin
          found_d     = 1'b1;
          hit_price_d = rd.price;
        end else begin
          idx_d = idx_inc;
        end
      end
      lob_pkg::S_CHK: begin
        if (op_q == lob_pkg::OP_ADD || op_q == lob_pkg::OP_MATCH) begin
          if (found_q) begin
            status_d = lob_pkg::ST_DUPLICATE;
          end else if (cnt_q[side_q] >= lob_pkg::CNT_W'(lob_pkg::SIDE_DEPTH)) begin
            status_d = lob_pkg::ST_SIDE_FULL;
          end else begin
            cur_side_d = side_q;
            idx_d      = '0;
          end
        end else if (!found_q) begin
          status_d = lob_pkg::ST_UNKNOWN_ID;
        end else if (op_q == lob_pkg::OP_MODIFY && vol_q != 32'd0) begin
          ram_we    = 1'b1;
          ram_wdata = '{id: id_q, price: hit_price_q, vol: vol_q};
        end
      end
      lob_pkg::S_FP_RD: begin
        if (idx_q >= cnt_q[side_q]) begin
          pos_d = idx_q;
        end
      end
      lob_pkg::S_FP_EV: begin
        if (better) begin
          pos_d = idx_q;
          idx_d = cnt_q[side_q];
        end else begin
          idx_d = idx_inc;
        end
      end
      lob_pkg::S_SH_RD: begin
        ram_raddr = {cur_side_q, idx_dec[lob_pkg::IDX_W-1:0]};
        if (idx_q == pos_q) begin
          ram_we           = 1'b1;
          cnt_d[cur_side_q] = cnt_q[cur_side_q] + lob_pkg::CNT_W'(1);
          rested_d         = vol_q;
        end
      end
      lob_pkg::S_SH_WR: begin
        // open the slot by moving entries one place toward the tail
        ram_we    = 1'b1;
        ram_wdata = rd;
        idx_d     = idx_dec;
      end
      lob_pkg::S_RM_RD: begin
        ram_raddr = {cur_side_q, idx_inc[lob_pkg::IDX_W-1:0]};
        if (idx_inc >= cnt_q[cur_side_q]) begin
          cnt_d[cur_side_q] = cnt_q[cur_side_q] - lob_pkg::CNT_W'(1);
          if (op_q == lob_pkg::OP_MATCH) begin
            cur_side_d = 1'b0;
            idx_d      = '0;
          end
        end
      end
      lob_pkg::S_RM_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
        idx_d     = idx_inc;
      end
      lob_pkg::S_MT_RD: begin
        ram_raddr = {opp, {lob_pkg::IDX_W{1'b0}}};
        cur_side_d = 1'b0;
        idx_d      = '0;
      end
      lob_pkg::S_MT_EV: begin
        if (crosses) begin
          vol_d    = vol_q - fill;
          traded_d = traded_q + fill;
          if (fill == rd.vol) begin
            cur_side_d = opp;
            idx_d      = '0;
          end else begin
            // partial fill of the head
            ram_we    = 1'b1;
            ram_waddr = {opp, {lob_pkg::IDX_W{1'b0}}};
            ram_wdata = '{id: rd.id, price: rd.price, vol: rd.vol - fill};
          end
        end
      end
      lob_pkg::S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lob_pkg::S_IDLE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q[0] <= cnt_d[0];
      cnt_q[1] <= cnt_d[1];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    side_q      <= side_d;
    price_q     <= price_d;
    vol_q       <= vol_d;
    traded_q    <= traded_d;
    rested_q    <= rested_d;
    status_q    <= status_d;
    found_q     <= found_d;
    hit_price_q <= hit_price_d;
    cur_side_q  <= cur_side_d;
    idx_q       <= idx_d;
    pos_q       <= pos_d;
  end

  assign idle_o = (state_q == lob_pkg::S_IDLE);
  assign done_o = (state_q == lob_pkg::S_FIN);
  assign res_o  = '{status: status_q, traded: traded_q, rested: rested_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= lob_pkg::CNT_W'(lob_pkg::SIDE_DEPTH) &&
    cnt_q[1] <= lob_pkg::CNT_W'(lob_pkg::SIDE_DEPTH))
    else $error("side count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (cnt_q[0] == $past(cnt_q[0]) || cnt_q[0] == $past(cnt_q[0]) + lob_pkg::CNT_W'(1) ||
         cnt_q[0] + lob_pkg::CNT_W'(1) == $past(cnt_q[0])))
    else $error("bid count moved by more than one");

  a_ack_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ack_i |=> idle_o)
    else $error("engine did not return to idle after result transfer");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> idle_o)
    else $error("start while engine busy");

endmodule

`default_nettype wire

// File: design/limit_order_book_top.sv
// Limit order book, price-time priority, bids best-high and asks best-low.
// Requests enter on in_i (opcode, order_id, side, price, volume) and each
// produces exactly one result on out_o (status, traded_volume, rested_volume).
// Both channels transfer when valid and ready are high at a rising clock edge.
// One request is worked at a time by a sequencer over a single book RAM with
// one read and one write port; each entry visited is first read, then compared
// or moved. A lookup of an id scans both sides. An add follows the lookup with
// a search for the insertion point and a shift toward the tail. A modify
// rewrites the entry in place; a delete, or a modify to zero volume, follows
// the lookup with a removal shift. A match trades against the opposite heads,
// removing each fully filled head, then rests any remainder as an add.
// in_i.ready is high whenever the sequencer is idle. The result sits in an
// output register, so a new request is taken while out_o stalls; the next
// result then waits until out_o takes the previous one.
// Reset empties both sides at once (counts cleared); the RAM itself is not
// swept, since entries beyond the count are never used.
`timescale 1ns / 1ps
`default_nettype none

module limit_order_book_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lob_in_if.sink     in_i,
  lob_out_if.source  out_o
);

  logic          start;
  logic          eng_idle, eng_done, eng_ack;
  lob_pkg::req_t req;
  lob_pkg::res_t eng_res;
  lob_pkg::res_t res_q, res_d;
  logic          out_valid_q, out_valid_d;

  assign in_i.ready = eng_idle;
  assign start      = in_i.valid && eng_idle;
  assign req        = '{op: lob_pkg::opcode_e'(in_i.opcode), id: in_i.order_id,
                        side: in_i.side, price: in_i.price, vol: in_i.volume};

  lob_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .idle_o  (eng_idle),
    .done_o  (eng_done),
    .res_o   (eng_res),
    .ack_i   (eng_ack)
  );

  // output register frees when its transfer completes
  assign eng_ack = eng_done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (eng_ack) begin
      out_valid_d = 1'b1;
      res_d       = eng_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.traded_volume = res_q.traded;
  assign out_o.rested_volume = res_q.rested;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(res_q))
    else $error("pending result changed under stall");

  a_ack_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_ack |=> out_valid_q)
    else $error("result handed over but output register empty");

  a_start_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !eng_done)
    else $error("request accepted while a result is pending in the engine");

endmodule

`default_nettype wire

// File: bench/tb_limit_order_book_top.sv
`timescale 1ns / 1ps

module tb_limit_order_book_top;

  typedef struct {
    lob_pkg::status_e status;
    logic [31:0]      traded;
    logic [31:0]      rested;
  } book_res_t;

  class book_scoreboard;
    lob_pkg::entry_t bids[$];
    lob_pkg::entry_t asks[$];
    book_res_t       pending[$];
    int unsigned     errors;

    function bit find_id(input logic [31:0] id, output bit s, output int pos);
      find_id = 1'b0;
      s = 1'b0;
      pos = 0;
      foreach (bids[i]) if (!find_id && bids[i].id == id) begin
        find_id = 1'b1; s = 1'b0; pos = i;
      end
      foreach (asks[i]) if (!find_id && asks[i].id == id) begin
        find_id = 1'b1; s = 1'b1; pos = i;
      end
    endfunction

    function lob_pkg::status_e rest(input bit s, input logic [31:0] id,
                                    input logic [31:0] price, input logic [31:0] vol);
      bit ds;
      int dp;
      int pos;
      lob_pkg::entry_t e;
      if (find_id(id, ds, dp)) return lob_pkg::ST_DUPLICATE;
      if ((s ? asks.size() : bids.size()) >= lob_pkg::SIDE_DEPTH) return lob_pkg::ST_SIDE_FULL;
      e.id = id; e.price = price; e.vol = vol;
      if (s) begin
        pos = asks.size();
        foreach (asks[i]) if (pos == asks.size() && price < asks[i].price) pos = i;
        asks.insert(pos, e);
      end else begin
        pos = bids.size();
        foreach (bids[i]) if (pos == bids.size() && price > bids[i].price) pos = i;
        bids.insert(pos, e);
      end
      return lob_pkg::ST_OK;
    endfunction

    function void note_request(input lob_pkg::req_t r);
      book_res_t res;
      bit fs;
      int fp;
      logic [31:0] rem, t;
      lob_pkg::entry_t hd;
      res.status = lob_pkg::ST_OK; res.traded = '0; res.rested = '0;
      case (r.op)
        lob_pkg::OP_ADD: begin
          res.status = rest(r.side, r.id, r.price, r.vol);
          if (res.status == lob_pkg::ST_OK) res.rested = r.vol;
        end
        lob_pkg::OP_MODIFY, lob_pkg::OP_DELETE: begin
          if (!find_id(r.id, fs, fp)) res.status = lob_pkg::ST_UNKNOWN_ID;
          else if (r.op == lob_pkg::OP_DELETE || r.vol == 0) begin
            if (fs) asks.delete(fp); else bids.delete(fp);
          end else if (fs) asks[fp].vol = r.vol;
          else bids[fp].vol = r.vol;
        end
        default: begin
          rem = r.vol;
          forever begin
            if (rem == 0) break;
            if (r.side ? bids.size() == 0 : asks.size() == 0) break;
            hd = r.side ? bids[0] : asks[0];
            if (r.side ? (r.price > hd.price) : (r.price < hd.price)) break;
            t = (rem < hd.vol) ? rem : hd.vol;
            rem -= t;
            res.traded += t;
            if (t == hd.vol) begin
              if (r.side) void'(bids.pop_front()); else void'(asks.pop_front());
            end else if (r.side) bids[0].vol -= t;
            else asks[0].vol -= t;
          end
          if (rem > 0) begin
            res.status = rest(r.side, r.id, r.price, rem);
            if (res.status == lob_pkg::ST_OK) res.rested = rem;
          end
        end
      endcase
      pending.push_back(res);
    endfunction

    task check_result(input logic [1:0] st, input logic [31:0] tr,
                      input logic [31:0] rs);
      book_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (st != e.status) report_mismatch($sformatf("status %0d exp %0d", st, e.status));
      if (tr != e.traded) report_mismatch($sformatf("traded %0d exp %0d", tr, e.traded));
      if (rs != e.rested) report_mismatch($sformatf("rested %0d exp %0d", rs, e.rested));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned fail_count = 0;
  localparam int unsigned CYCLE_LIMIT = 50000000;

  lob_in_if  in_ch();
  lob_out_if out_ch();

  limit_order_book_top dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  book_scoreboard book = new();
  logic [31:0] used_ids[$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    fail_count++;
  endtask

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_limit_order_book_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  // result side: random stall, check on transfer
  initial begin
    int unsigned g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      book.check_result(out_ch.status, out_ch.traded_volume, out_ch.rested_volume);
  end

  task automatic send_request(input lob_pkg::opcode_e op, input logic [31:0] id,
                              input logic s, input logic [31:0] price,
                              input logic [31:0] vol);
    lob_pkg::req_t r;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.order_id <= id;
    in_ch.side     <= s;
    in_ch.price    <= price;
    in_ch.volume   <= vol;
    do @(posedge clk_i); while (!in_ch.ready);
    r.op = op; r.id = id; r.side = s; r.price = price; r.vol = vol;
    book.note_request(r);
    used_ids.push_back(id);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 300);
  endfunction

  function automatic logic [31:0] pick_price();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom();
      default: return 32'd1000 + $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [31:0] pick_vol();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  initial begin
    lob_pkg::opcode_e op;
    in_ch.valid = 1'b0;
    in_ch.opcode = lob_pkg::OP_ADD;
    in_ch.order_id = '0;
    in_ch.side = 1'b0;
    in_ch.price = '0;
    in_ch.volume = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes and every special case
    send_request(lob_pkg::OP_MODIFY, 32'd5, 1'b0, 32'd0, 32'd7);
    send_request(lob_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0);
    send_request(lob_pkg::OP_ADD, 32'd1, 1'b0, 32'd100, 32'd10);
    send_request(lob_pkg::OP_ADD, 32'd1, 1'b1, 32'd200, 32'd10);
    send_request(lob_pkg::OP_ADD, 32'd2, 1'b0, 32'd100, 32'd0);
    send_request(lob_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lob_pkg::OP_ADD, 32'd3, 1'b1, 32'd150, 32'd5);
    send_request(lob_pkg::OP_MATCH, 32'd4, 1'b0, 32'd50, 32'd8);
    send_request(lob_pkg::OP_MATCH, 32'd9, 1'b0, 32'd150, 32'd0);
    send_request(lob_pkg::OP_MATCH, 32'd10, 1'b0, 32'd160, 32'd3);
    send_request(lob_pkg::OP_MATCH, 32'd11, 1'b1, 32'd0, 32'd30);
    send_request(lob_pkg::OP_MATCH, 32'd3, 1'b0, 32'hFFFF_FFFF, 32'd4);
    send_request(lob_pkg::OP_MODIFY, 32'd3, 1'b0, 32'd0, 32'd9);
    send_request(lob_pkg::OP_MODIFY, 32'd3, 1'b0, 32'd0, 32'd0);
    send_request(lob_pkg::OP_DELETE, 32'd4, 1'b0, 32'd0, 32'd0);
    send_request(lob_pkg::OP_MATCH, 32'd12, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < lob_pkg::SIDE_DEPTH + 1; i++)
      send_request(lob_pkg::OP_ADD, 32'd500 + i, 1'b0, 32'd10 + (i % 5), 32'd1);
    send_request(lob_pkg::OP_MATCH, 32'd900, 1'b1, 32'd20, 32'd2);
    send_request(lob_pkg::OP_MATCH, 32'd901, 1'b0, 32'd5, 32'd2);
    send_request(lob_pkg::OP_MATCH, 32'd902, 1'b0, 32'd5, 32'd2);
    // hold off until the book is quiet
    drain();
    for (int i = 0; i < lob_pkg::SIDE_DEPTH; i++)
      send_request(lob_pkg::OP_DELETE, 32'd500 + i, 1'b0, 32'd0, 32'd0);

    for (int n = 0; n < 1100; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: op = lob_pkg::OP_ADD;
        3: op = lob_pkg::OP_MODIFY;
        4: op = lob_pkg::OP_DELETE;
        default: op = lob_pkg::OP_MATCH;
      endcase
      send_request(op, pick_id(), 1'($urandom()), pick_price(), pick_vol());
    end

    drain();
    if (fail_count == 0 && book.pending.size() == 0) begin
      $display("tb_limit_order_book_top: PASS");
    end else begin
      $display("tb_limit_order_book_top: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/lob_pkg.sv
design/lob_if.sv
design/lob_ram.sv
design/lob_engine.sv
design/limit_order_book_top.sv
bench/tb_limit_order_book_top.sv
